### rtl/twdbg_pkg.sv
// Shared types and constants for the two-wire debug serial master.
// No dependencies; the front, back and top-level files import this package.
package twdbg_pkg;

  // Input action codes as they arrive on the command channel.
  localparam logic [1:0] ACT_SEND = 2'd0;
  localparam logic [1:0] ACT_READ = 2'd1;
  localparam logic [1:0] ACT_CLKS = 2'd2;
  localparam logic [1:0] ACT_TICK = 2'd3;

  // Operation in progress inside the engine.
  localparam logic [1:0] OP_IDLE = 2'd0;
  localparam logic [1:0] OP_SEND = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;
  localparam logic [1:0] OP_CLKS = 2'd3;

  // Segment of a word transfer on the wire.
  localparam logic [1:0] SEG_START = 2'd0;
  localparam logic [1:0] SEG_BITS  = 2'd1;
  localparam logic [1:0] SEG_STOP  = 2'd2;

  // Classified command as it sits in the queue between front and back.
  typedef struct packed {
    logic [1:0] action;
    logic       start_bit_on;
    logic       stop_value;
    logic [7:0] data_byte;
    logic [7:0] idle_count;
    logic       idle_zero;
    logic       sampled_data;
  } cmd_t;

  // One result item as held in the output register.
  typedef struct packed {
    logic       clock_level;
    logic       data_level;
    logic       data_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       rejected;
  } res_t;

endpackage

### rtl/twdbg_if.sv
// Channel interfaces for the command input and the result output.
// Depends on nothing; used by the top level and its submodules.
interface twdbg_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic       start_bit_on;
  logic       stop_value;
  logic [7:0] data_byte;
  logic [7:0] idle_count;
  logic       sampled_data;

  modport source (output valid, action, start_bit_on, stop_value, data_byte,
                  idle_count, sampled_data, input ready);
  modport sink (input valid, action, start_bit_on, stop_value, data_byte,
                idle_count, sampled_data, output ready);
endinterface

interface twdbg_out_if;
  logic       valid;
  logic       ready;
  logic       clock_level;
  logic       data_level;
  logic       data_drive;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_byte;
  logic       rejected;

  modport source (output valid, clock_level, data_level, data_drive, busy_res,
                  done_res, read_byte, rejected, input ready);
  modport sink (input valid, clock_level, data_level, data_drive, busy_res,
                done_res, read_byte, rejected, output ready);
endinterface

### rtl/twdbg_front.sv
// Front end: accepts command transfers, classifies them and queues them.
// Depends on twdbg_pkg and twdbg_in_if.
module twdbg_front (
  input  logic             clk,
  input  logic             rst_n,
  twdbg_in_if.sink         in_ch,
  output logic             q_valid,
  output twdbg_pkg::cmd_t  q_item,
  input  logic             q_pop
);
  import twdbg_pkg::*;

  localparam int QDEPTH = 2;

  cmd_t       mem_r [QDEPTH];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  cmd_t       cls;
  logic       push;

  // Classify the incoming transfer; the zero idle count is flagged early.
  always_comb begin
    cls.action       = in_ch.action;
    cls.start_bit_on = in_ch.start_bit_on;
    cls.stop_value   = in_ch.stop_value;
    cls.data_byte    = in_ch.data_byte;
    cls.idle_count   = in_ch.idle_count;
    cls.idle_zero    = (in_ch.idle_count == 8'd0);
    cls.sampled_data = in_ch.sampled_data;
  end

  assign in_ch.ready = (count_r != 2'(QDEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (count_r != 2'd0);
  assign q_item      = mem_r[rd_ptr_r];

  // Queue pointers and fill count.
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= cls;
    end
  end

endmodule

### rtl/twdbg_back.sv
// Back end: the wire sequencer that executes queued commands and ticks,
// with a registered result stage. Depends on twdbg_pkg and twdbg_out_if.
module twdbg_back #(
  parameter int BITS_PER_WORD = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  twdbg_pkg::cmd_t  q_item,
  output logic             q_pop,
  twdbg_out_if.source      out_ch
);
  import twdbg_pkg::*;

  localparam int BW = BITS_PER_WORD;
  localparam int PW = $clog2(BW + 1);

  logic [1:0]    op_r, op_nxt;
  logic [1:0]    phase_r, phase_nxt;
  logic [1:0]    seg_r, seg_nxt;
  logic [PW-1:0] bitpos_r, bitpos_nxt;
  logic [BW-1:0] shift_r, shift_nxt;
  logic [BW-1:0] last_read_r, last_read_nxt;
  logic [7:0]    pulses_r, pulses_nxt;
  logic          stop_lvl_r, stop_lvl_nxt;
  logic          clk_pin_r, clk_pin_nxt;
  logic          dat_pin_r, dat_pin_nxt;
  logic          drive_r, drive_nxt;
  logic          done, rej;
  logic          out_valid_r, out_valid_nxt;
  res_t          res_r, res_nxt;

  // An item is taken once the result register is free or being emptied.
  assign q_pop = q_valid && (!out_valid_r || out_ch.ready);

  // Sequencer: one tick advances the wire by one delay period.
  always_comb begin
    op_nxt        = op_r;
    phase_nxt     = phase_r;
    seg_nxt       = seg_r;
    bitpos_nxt    = bitpos_r;
    shift_nxt     = shift_r;
    last_read_nxt = last_read_r;
    pulses_nxt    = pulses_r;
    stop_lvl_nxt  = stop_lvl_r;
    clk_pin_nxt   = clk_pin_r;
    dat_pin_nxt   = dat_pin_r;
    drive_nxt     = drive_r;
    done          = 1'b0;
    rej           = 1'b0;
    if (q_item.action == ACT_TICK) begin
      if (op_r == OP_CLKS) begin
        // Idle clocks: low period then high period per pulse.
        if (phase_r == 2'd0) begin
          clk_pin_nxt = 1'b0;
          phase_nxt   = 2'd1;
        end else begin
          clk_pin_nxt = 1'b1;
          phase_nxt   = 2'd0;
          pulses_nxt  = pulses_r - 8'd1;
          if (pulses_nxt == 8'd0) begin
            op_nxt = OP_IDLE;
            done   = 1'b1;
          end
        end
      end else if (op_r != OP_IDLE) begin
        unique case (seg_r)
          SEG_START: begin
            if (op_r == OP_SEND) begin
              if (phase_r == 2'd0) begin
                clk_pin_nxt = 1'b0;
                phase_nxt   = 2'd1;
              end else if (phase_r == 2'd1) begin
                dat_pin_nxt = 1'b0;
                phase_nxt   = 2'd2;
              end else begin
                clk_pin_nxt = 1'b1;
                phase_nxt   = 2'd0;
                seg_nxt     = SEG_BITS;
              end
            end else begin
              if (phase_r == 2'd0) begin
                clk_pin_nxt = 1'b0;
                dat_pin_nxt = 1'b0;
                phase_nxt   = 2'd1;
              end else begin
                clk_pin_nxt = 1'b1;
                phase_nxt   = 2'd0;
                seg_nxt     = SEG_BITS;
              end
            end
          end
          SEG_BITS: begin
            if (phase_r == 2'd0) begin
              clk_pin_nxt = 1'b0;
              if (op_r == OP_SEND) begin
                dat_pin_nxt = shift_r[0];
              end else begin
                // Release the line and shift the sample in at the top.
                drive_nxt            = 1'b0;
                shift_nxt            = shift_r >> 1;
                shift_nxt[BW-1]      = q_item.sampled_data;
              end
              phase_nxt = 2'd1;
            end else begin
              clk_pin_nxt = 1'b1;
              if (op_r == OP_SEND) begin
                shift_nxt = shift_r >> 1;
              end
              phase_nxt  = 2'd0;
              bitpos_nxt = bitpos_r + PW'(1);
              if (bitpos_nxt >= PW'(BW)) begin
                seg_nxt = SEG_STOP;
              end
            end
          end
          default: begin
            // Stop bit: take the line back and drive the chosen level.
            if (phase_r == 2'd0) begin
              drive_nxt   = 1'b1;
              clk_pin_nxt = 1'b0;
              dat_pin_nxt = stop_lvl_r;
              phase_nxt   = 2'd1;
            end else begin
              clk_pin_nxt = 1'b1;
              phase_nxt   = 2'd0;
              if (op_r == OP_READ) begin
                last_read_nxt = shift_r;
              end
              op_nxt = OP_IDLE;
              done   = 1'b1;
            end
          end
        endcase
      end
    end else if (op_r != OP_IDLE) begin
      rej = 1'b1;
    end else begin
      // New command: latch operands; clocking starts on the next tick.
      stop_lvl_nxt = q_item.stop_value;
      phase_nxt    = 2'd0;
      bitpos_nxt   = '0;
      seg_nxt      = q_item.start_bit_on ? SEG_START : SEG_BITS;
      unique case (q_item.action)
        ACT_SEND: begin
          op_nxt    = OP_SEND;
          shift_nxt = BW'(q_item.data_byte);
        end
        ACT_READ: begin
          op_nxt    = OP_READ;
          shift_nxt = '0;
        end
        default: begin
          dat_pin_nxt = 1'b1;
          pulses_nxt  = q_item.idle_count;
          if (q_item.idle_zero) begin
            done = 1'b1;
          end else begin
            op_nxt = OP_CLKS;
          end
        end
      endcase
    end
  end

  // Result built from the state after this item.
  always_comb begin
    res_nxt.clock_level = clk_pin_nxt;
    res_nxt.data_level  = dat_pin_nxt;
    res_nxt.data_drive  = drive_nxt;
    res_nxt.busy_res    = (op_nxt != OP_IDLE);
    res_nxt.done_res    = done;
    res_nxt.read_byte   = 8'(last_read_nxt);
    res_nxt.rejected    = rej;
  end

  assign out_valid_nxt = q_pop ? 1'b1 : (out_valid_r && !out_ch.ready);

  // Sequencer state, updated only when an item is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r        <= OP_IDLE;
      phase_r     <= 2'd0;
      seg_r       <= SEG_START;
      bitpos_r    <= '0;
      shift_r     <= '0;
      last_read_r <= '0;
      pulses_r    <= 8'd0;
      stop_lvl_r  <= 1'b0;
      clk_pin_r   <= 1'b0;
      dat_pin_r   <= 1'b0;
      drive_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (q_pop) begin
        op_r        <= op_nxt;
        phase_r     <= phase_nxt;
        seg_r       <= seg_nxt;
        bitpos_r    <= bitpos_nxt;
        shift_r     <= shift_nxt;
        last_read_r <= last_read_nxt;
        pulses_r    <= pulses_nxt;
        stop_lvl_r  <= stop_lvl_nxt;
        clk_pin_r   <= clk_pin_nxt;
        dat_pin_r   <= dat_pin_nxt;
        drive_r     <= drive_nxt;
      end
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.clock_level = res_r.clock_level;
  assign out_ch.data_level  = res_r.data_level;
  assign out_ch.data_drive  = res_r.data_drive;
  assign out_ch.busy_res    = res_r.busy_res;
  assign out_ch.done_res    = res_r.done_res;
  assign out_ch.read_byte   = res_r.read_byte;
  assign out_ch.rejected    = res_r.rejected;

`ifndef SYNTHESIS
  // A finished command never reports itself as still busy.
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.done_res |-> !res_r.busy_res)
    else $error("done reported together with busy");

  // A rejected command leaves the running one in place.
  a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.rejected |-> res_r.busy_res && !res_r.done_res)
    else $error("rejection without a command in progress");

  // The data line is always driven again once the engine is idle.
  a_idle_drives: assert property (@(posedge clk) disable iff (!rst_n)
    op_r == OP_IDLE |-> drive_r)
    else $error("data line left released while idle");

  // The stop segment is reached only after the whole word.
  a_stop_count: assert property (@(posedge clk) disable iff (!rst_n)
    seg_r == SEG_STOP |-> bitpos_r == PW'(BW))
    else $error("stop bit before the last data bit");
`endif

endmodule

### rtl/two_wire_debug_serial_master.sv
// Top level of the two-wire debug serial master: front queue plus engine.
// Depends on twdbg_pkg, twdbg_if, twdbg_front and twdbg_back.
//
//   channel  direction  role
//   in_ch    sink       command or tick transfer (action, operands, sample)
//   out_ch   source     one result transfer per accepted input transfer
//
// One input transfer per clock is sustained while out_ch takes results; the
// engine handles each item combinationally, so the rate is set by the output
// register alone. A result is presented on out_ch after its input has passed
// through a queue entry and then the result register. A two-entry queue
// between the front and the engine absorbs output stalls; in_ch.ready falls
// only when it is full.
// Reset is synchronous and active low; no clearing pass.
module two_wire_debug_serial_master #(
  parameter int BITS_PER_WORD = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  twdbg_in_if.sink     in_ch,
  twdbg_out_if.source  out_ch
);
  import twdbg_pkg::*;

  logic q_valid;
  logic q_pop;
  cmd_t q_item;

  // Command acceptance and queue.
  twdbg_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  // Wire sequencer and result register.
  twdbg_back #(
    .BITS_PER_WORD (BITS_PER_WORD)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
